// File: hw/rtl/bhpq_pkg.sv
// Shared constants, codes and controller/datapath command and status types.
package bhpq_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned CNT_OUT_W    = 6;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_POP    = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    ins_begin;
    logic    rd_parent;
    logic    up_move;
    logic    place;
    logic    rd_ends;
    logic    pop_load;
    logic    rd_kids;
    logic    down_move;
    logic    rsp_load;
    logic    rsp_pop;
    status_e rsp_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic up_go;
    logic leaf;
    logic down_go;
  } sts_t;

endpackage

// File: hw/rtl/bhpq_req_if.sv
// Request channel interface: valid/ready handshake with the request payload.
interface bhpq_req_if import bhpq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [KEY_W-1:0] key_in;

  modport source (output valid, output req_type, output key_in, input ready);
  modport sink (input valid, input req_type, input key_in, output ready);
endinterface

// File: hw/rtl/bhpq_rsp_if.sv
// Response channel interface: valid/ready handshake with the response payload.
interface bhpq_rsp_if import bhpq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [KEY_W-1:0]     popped_key;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (output valid, output status, output popped_key, output entry_count,
                  input ready);
  modport sink (input valid, input status, input popped_key, input entry_count,
                output ready);
endinterface

// File: hw/rtl/bhpq_dp.sv
// Heap datapath: key store, position and count registers, compares and response register.
module bhpq_dp import bhpq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [KEY_W-1:0]     key_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic [1:0]           rsp_status_o,
  output logic [KEY_W-1:0]     rsp_popped_key_o,
  output logic [CNT_OUT_W-1:0] rsp_entry_count_o
);

  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned LW    = AW + 2;

  logic [KEY_W-1:0] mem_q [CAPACITY];

  logic [CNT_W-1:0]        count_q, count_d;
  logic [AW-1:0]           pos_q, pos_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [KEY_W-1:0]        popped_q, popped_d;
  logic signed [KEY_W-1:0] rd0_q, rd1_q;

  logic [1:0]           rsp_status_q;
  logic [KEY_W-1:0]     rsp_popped_q;
  logic [CNT_OUT_W-1:0] rsp_count_q;

  logic [AW-1:0]           parent, last, best_idx, raddr0, raddr1, waddr;
  logic [LW-1:0]           kid_l, kid_r, count_w;
  logic                    l_gt, r_ok, r_gt, we;
  logic signed [KEY_W-1:0] left_or_key, best_val;
  logic [KEY_W-1:0]        wdata;

  assign parent  = (pos_q - AW'(1)) >> 1;
  assign last    = AW'(count_q - CNT_W'(1));
  assign kid_l   = {1'b0, pos_q, 1'b1};
  assign kid_r   = kid_l + LW'(1);
  assign count_w = LW'(count_q);

  // Sift-down choice: left child wins a tie, and an equal child never displaces the key.
  assign r_ok        = kid_r < count_w;
  assign l_gt        = rd0_q > key_q;
  assign left_or_key = l_gt ? rd0_q : key_q;
  assign r_gt        = r_ok && (rd1_q > left_or_key);
  assign best_idx    = r_gt ? kid_r[AW-1:0] : kid_l[AW-1:0];
  assign best_val    = r_gt ? rd1_q : rd0_q;

  assign sts_o.full    = count_q == CNT_W'(CAPACITY);
  assign sts_o.empty   = count_q == '0;
  assign sts_o.at_root = pos_q == '0;
  assign sts_o.up_go   = key_q > rd0_q;
  assign sts_o.leaf    = kid_l >= count_w;
  assign sts_o.down_go = l_gt || r_gt;

  always_comb begin
    raddr0 = '0;
    raddr1 = last;
    if (cmd_i.rd_parent) begin
      raddr0 = parent;
    end else if (cmd_i.rd_kids) begin
      raddr0 = kid_l[AW-1:0];
      raddr1 = kid_r[AW-1:0];
    end
  end

  // The moving key stays in key_q; only the vacated slot is written each level.
  always_comb begin
    we    = cmd_i.place || cmd_i.up_move || cmd_i.down_move;
    waddr = pos_q;
    wdata = key_q;
    if (cmd_i.up_move) begin
      wdata = rd0_q;
    end else if (cmd_i.down_move) begin
      wdata = best_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd0_q <= mem_q[raddr0];
    rd1_q <= mem_q[raddr1];
  end

  always_comb begin
    count_d  = count_q;
    pos_d    = pos_q;
    key_d    = key_q;
    popped_d = popped_q;
    if (cmd_i.ins_begin) begin
      count_d = count_q + CNT_W'(1);
      pos_d   = AW'(count_q);
      key_d   = key_i;
    end
    if (cmd_i.rd_ends) begin
      count_d = count_q - CNT_W'(1);
    end
    if (cmd_i.up_move) begin
      pos_d = parent;
    end
    if (cmd_i.pop_load) begin
      pos_d    = '0;
      key_d    = rd1_q;
      popped_d = rd0_q;
    end
    if (cmd_i.down_move) begin
      pos_d = best_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    key_q    <= key_d;
    popped_q <= popped_d;
    if (cmd_i.rsp_load) begin
      rsp_status_q <= cmd_i.rsp_status;
      rsp_popped_q <= cmd_i.rsp_pop ? popped_q : '0;
      rsp_count_q  <= CNT_OUT_W'(count_q);
    end
  end

  assign rsp_status_o      = rsp_status_q;
  assign rsp_popped_key_o  = rsp_popped_q;
  assign rsp_entry_count_o = rsp_count_q;

endmodule

// File: hw/rtl/bhpq_ctrl.sv
// Heap controller: state machine sequencing insert and pop sifts and the response handshake.
module bhpq_ctrl import bhpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_type_i,
  output logic req_ready_o,
  input  logic rsp_ready_i,
  output logic rsp_valid_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_ST,
    S_POP_RD,
    S_POP_LD,
    S_DN_RD,
    S_DN_ST,
    S_FIN
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;
  logic    pop_ok_q, pop_ok_d;
  logic    rsp_valid_q, rsp_valid_d;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    pop_ok_d = pop_ok_q;
    cmd_o    = '0;
    cmd_o.rsp_status = status_q;
    cmd_o.rsp_pop    = pop_ok_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          if (req_e'(req_type_i) == REQ_POP) begin
            if (sts_i.empty) begin
              status_d = ST_EMPTY;
              pop_ok_d = 1'b0;
              state_d  = S_FIN;
            end else begin
              status_d = ST_OK;
              pop_ok_d = 1'b1;
              state_d  = S_POP_RD;
            end
          end else begin
            pop_ok_d = 1'b0;
            if (sts_i.full) begin
              status_d = ST_FULL;
              state_d  = S_FIN;
            end else begin
              status_d        = ST_OK;
              cmd_o.ins_begin = 1'b1;
              state_d         = S_UP_RD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (sts_i.at_root) begin
          cmd_o.place = 1'b1;
          state_d     = S_FIN;
        end else begin
          cmd_o.rd_parent = 1'b1;
          state_d         = S_UP_ST;
        end
      end
      S_UP_ST: begin
        if (sts_i.up_go) begin
          cmd_o.up_move = 1'b1;
          state_d       = S_UP_RD;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_FIN;
        end
      end
      S_POP_RD: begin
        cmd_o.rd_ends = 1'b1;
        state_d       = S_POP_LD;
      end
      S_POP_LD: begin
        cmd_o.pop_load = 1'b1;
        state_d        = S_DN_RD;
      end
      S_DN_RD: begin
        if (sts_i.leaf) begin
          cmd_o.place = 1'b1;
          state_d     = S_FIN;
        end else begin
          cmd_o.rd_kids = 1'b1;
          state_d       = S_DN_ST;
        end
      end
      S_DN_ST: begin
        if (sts_i.down_go) begin
          cmd_o.down_move = 1'b1;
          state_d         = S_DN_RD;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_FIN;
        end
      end
      S_FIN: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.rsp_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_OK;
      pop_ok_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      pop_ok_q    <= pop_ok_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign req_ready_o = state_q == S_IDLE;
  assign rsp_valid_o = rsp_valid_q;

endmodule

// File: hw/rtl/binary_heap_priority_queue.sv
// Top level of the binary max-heap priority queue.
//
// This block keeps up to CAPACITY signed 32-bit keys in a binary max-heap held in an
// on-chip memory with one write port and two registered read ports. Each request either
// inserts key_in or pops the largest key, and every request yields exactly one response
// carrying a status (ok, insert dropped because the heap is full, or pop on an empty
// heap), the popped key (zero unless a pop succeeded) and the number of keys held after
// the request. Requests are handled one at a time. Each heap level visited by a sift
// takes a read of the memory and then a compare that writes the vacated slot, and a
// key moves at most log2(CAPACITY) levels. A finished response waits until the output
// register is free, that is until the previous response has been read, and only then
// is the next request taken. Ties resolve as follows: an inserted key stops below an
// equal parent, and during a pop the left child wins a tie between children and a
// child equal to the moving key stays put.
module binary_heap_priority_queue import bhpq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bhpq_req_if.sink    req_i,
  bhpq_rsp_if.source  rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // Controller: sequences the sift steps and owns both handshakes.
  bhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: heap memory, moving key, position, count and response payload.
  bhpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .key_i             (req_i.key_in),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .rsp_status_o      (rsp_o.status),
    .rsp_popped_key_o  (rsp_o.popped_key),
    .rsp_entry_count_o (rsp_o.entry_count)
  );

  // The heap can never be full and empty at once.
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sts.full && sts.empty))
    else $error("heap reports full and empty together");

  // The engine is not ready in the cycle after it takes a request.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while the previous one is still in progress");

  // A dropped insert leaves a full heap and returns no key.
  a_full_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status == ST_FULL) |->
      (rsp_o.popped_key == '0) && (rsp_o.entry_count == CNT_OUT_W'(CAPACITY)))
    else $error("full response with a key or a wrong count");

  // A pop on an empty heap returns zero and an empty count.
  a_empty_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status == ST_EMPTY) |->
      (rsp_o.popped_key == '0) && (rsp_o.entry_count == '0))
    else $error("empty response with a key or a nonzero count");

endmodule

// File: verif/bhpq_heap_check_pkg.sv
// Shadow max-heap that predicts each response of the priority queue and checks it.
package bhpq_heap_check_pkg;
  import bhpq_pkg::*;

  typedef struct {
    status_e              status;
    logic [KEY_W-1:0]     popped_key;
    logic [CNT_OUT_W-1:0] entry_count;
  } heap_rsp_t;

  class heap_shadow;
    logic signed [KEY_W-1:0] keys [CAPACITY_DEF];
    int unsigned             fill;
    heap_rsp_t               awaited_responses [$];
    int unsigned             mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return awaited_responses.size();
    endfunction

    function void swap_keys(int unsigned a, int unsigned b);
      logic signed [KEY_W-1:0] t;
      t       = keys[a];
      keys[a] = keys[b];
      keys[b] = t;
    endfunction

    // Applies one accepted request to the shadow heap and queues its response.
    function void note_request(req_e kind, logic [KEY_W-1:0] key);
      heap_rsp_t   rsp;
      int unsigned pos;
      int unsigned parent;
      int unsigned left;
      int unsigned best;
      rsp.status     = ST_OK;
      rsp.popped_key = '0;
      if (kind == REQ_INSERT) begin
        if (fill >= CAPACITY_DEF) begin
          rsp.status = ST_FULL;
        end else begin
          pos       = fill;
          keys[pos] = key;
          fill++;
          // An equal parent stops the climb.
          while (pos != 0) begin
            parent = (pos - 1) / 2;
            if (keys[pos] <= keys[parent]) break;
            swap_keys(pos, parent);
            pos = parent;
          end
        end
      end else if (fill == 0) begin
        rsp.status = ST_EMPTY;
      end else begin
        rsp.popped_key = keys[0];
        fill--;
        keys[0] = keys[fill];
        pos     = 0;
        // The left child wins ties, and a child equal to the moving key stays put.
        while (pos < fill) begin
          left = 2 * pos + 1;
          best = pos;
          if (left < fill && keys[left] > keys[best]) best = left;
          if (left + 1 < fill && keys[left + 1] > keys[best]) best = left + 1;
          if (best == pos) break;
          swap_keys(pos, best);
          pos = best;
        end
      end
      rsp.entry_count = CNT_OUT_W'(fill);
      awaited_responses.push_back(rsp);
    endfunction

    function void check_response(logic [1:0] status, logic [KEY_W-1:0] popped_key,
                                 logic [CNT_OUT_W-1:0] entry_count);
      heap_rsp_t want;
      if (awaited_responses.size() == 0) begin
        $error("unexpected response: status %0d popped_key %0d entry_count %0d",
               status, $signed(popped_key), entry_count);
        mismatches++;
        return;
      end
      want = awaited_responses.pop_front();
      if (status !== 2'(want.status)) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        mismatches++;
      end
      if (popped_key !== want.popped_key) begin
        $error("popped_key: expected %0d, actual %0d", $signed(want.popped_key),
               $signed(popped_key));
        mismatches++;
      end
      if (entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count, entry_count);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// File: verif/tb_binary_heap_priority_queue.sv
// Self-checking testbench for the binary max-heap priority queue.
module tb_binary_heap_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import bhpq_pkg::*;
  import bhpq_heap_check_pkg::*;

  // Roughly 1500 random requests follow the directed opening.
  localparam int unsigned RANDOM_REQUESTS = 1500;
  // The receiver holds off once, well into the random part, for this many cycles.
  localparam int unsigned HOLD_OFF_AT     = 600;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // Settle time after the drain; it comfortably covers the slowest request.
  localparam int unsigned SETTLE_CYCLES   = 40;
  // Time limit for the whole run; a correct run finishes well within it.
  localparam realtime     RUN_LIMIT       = 2ms;

  // Keys at the corners of the signed range, plus repeats that exercise the tie rules.
  localparam logic [KEY_W-1:0] BOUNDARY_KEYS [9] = '{
    32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 32'h8000_0000
  };

  logic clk_i;
  logic rst_ni;

  bhpq_req_if req_if ();
  bhpq_rsp_if rsp_if ();

  binary_heap_priority_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  heap_shadow  board;
  int unsigned requests_taken;
  int unsigned burst_left;

  // Clock with a 4 ns period; reset is held low only at the start of the run.
  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    fork
      forever #2 clk_i = ~clk_i;
      begin
        repeat (4) @(posedge clk_i);
        rst_ni <= 1'b1;
      end
    join_none
  end

  // Hard stop in case the block hangs or loses a response.
  initial begin
    #(RUN_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly full-range keys, with a good share of small values so that equal keys
  // meet each other in the heap, and an occasional key at the edge of the range.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return BOUNDARY_KEYS[$urandom_range(0, 3)];
      1, 2, 3: return KEY_W'(int'($urandom_range(0, 8)) - 4);
      default: return $urandom();
    endcase
  endfunction

  // Offers one request and returns once the block has taken it. The sender works in
  // bursts: between bursts it may drop valid for a random gap, and sometimes it skips
  // the gap so that long back-to-back stretches occur as well. Valid is only lowered
  // at the start of a gap, so it never falls and rises within one time step.
  task automatic offer_request(input req_e kind, input logic [KEY_W-1:0] key);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.key_in   <= key;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    board.note_request(kind, key);
    requests_taken++;
  endtask

  // Request side: directed opening, then random phases, then the drain and verdict.
  initial begin : sender
    int unsigned insert_weight;
    int unsigned phase_len;
    req_e        kind;
    board           = new();
    requests_taken  = 0;
    burst_left      = 0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_INSERT;
    req_if.key_in   <= '0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Directed part. A pop on the empty heap comes first, then keys at the edges of
    // the signed range and a few repeats, then enough pops to empty the heap and hit
    // the empty case once more. Sifting the repeated fives down exercises the rule
    // that the left child wins a tie and that an equal child does not swap.
    offer_request(REQ_POP, 32'hFFFF_FFFF);
    foreach (BOUNDARY_KEYS[i]) offer_request(REQ_INSERT, BOUNDARY_KEYS[i]);
    repeat ($size(BOUNDARY_KEYS) + 1) offer_request(REQ_POP, pick_key());

    // Random part in phases. Insert-heavy phases push the heap to its capacity, so
    // dropped inserts show up; pop-heavy phases drain it to empty; balanced phases
    // keep the heap at middling depth where sifts are long and varied. Pops carry
    // random keys too, since the block must ignore them.
    while (requests_taken < RANDOM_REQUESTS + 20) begin
      case ($urandom_range(0, 2))
        0:       insert_weight = 85;
        1:       insert_weight = 15;
        default: insert_weight = 50;
      endcase
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) begin
        kind = ($urandom_range(1, 100) <= insert_weight) ? REQ_INSERT : REQ_POP;
        offer_request(kind, pick_key());
      end
    end
    req_if.valid <= 1'b0;

    // Let every outstanding response come back, then give stray ones a chance to show.
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Response side. Ready follows a randomly drawn mode: always ready, ready half the
  // time, or mostly stalled. Once, after enough requests have gone in, the receiver
  // refuses everything for a long stretch while the sender keeps offering, so the
  // output register fills and the block has to stall its input.
  initial begin : receiver
    int unsigned mode;
    int unsigned cycle;
    bit          held;
    rsp_if.ready <= 1'b0;
    mode  = 0;
    cycle = 0;
    held  = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!held && requests_taken >= HOLD_OFF_AT) begin
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      if (cycle % 64 == 0) mode = $urandom_range(0, 2);
      cycle++;
      case (mode)
        0:       rsp_if.ready <= 1'b1;
        1:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
        default: rsp_if.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Every accepted response is compared with the oldest prediction. Values are taken
  // as they stood at the edge, before anything driven at this edge takes effect.
  always @(posedge clk_i) begin
    if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      board.check_response(rsp_if.status, rsp_if.popped_key, rsp_if.entry_count);
    end
  end

endmodule
